// File: rtl/lsr_pkg.sv
// Shared types and constants of the line span rasteriser.
package lsr_pkg;

    localparam int COORD_BITS     = 12;
    localparam int FIELD_BITS     = 11;
    localparam int COLOR_BITS     = 16;
    localparam int CFG_INDEX_BITS = 1;
    // internal signed width: room for any coordinate, any limit and one step past the end
    localparam int WIDE_BITS      = ((COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS) + 2;

    localparam logic [FIELD_BITS-1:0] WIDTH_RESET  = FIELD_BITS'(320);
    localparam logic [FIELD_BITS-1:0] HEIGHT_RESET = FIELD_BITS'(480);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;
    typedef logic [FIELD_BITS-1:0]        field_t;
    typedef logic [COLOR_BITS-1:0]        color_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        field_t span_x;
        field_t span_y;
        field_t span_length;
        logic   span_vertical;
        color_t span_color;
        logic   line_done;
    } span_t;

endpackage

// File: rtl/lsr_engine.sv
// Line state, load setup, Bresenham step and span clipping.
module lsr_engine import lsr_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      item_accept,
    input  logic                      command,
    input  coord_t                    start_x,
    input  coord_t                    start_y,
    input  coord_t                    end_x,
    input  coord_t                    end_y,
    input  color_t                    line_color,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  field_t                    cfg_data,
    output logic                      span_valid,
    output span_t                     span
);

    field_t width_reg, width_next;
    field_t height_reg, height_next;
    logic   active_reg, active_next;
    logic   steep_reg, steep_next;
    wide_t  major_pos_reg, major_pos_next;
    wide_t  major_end_reg, major_end_next;
    wide_t  minor_pos_reg, minor_pos_next;
    wide_t  run_start_reg, run_start_next;
    wide_t  error_reg, error_next;
    wide_t  delta_major_reg, delta_major_next;
    wide_t  delta_minor_reg, delta_minor_next;
    logic   step_down_reg, step_down_next;
    color_t color_reg, color_next;

    wide_t  w, h;
    wide_t  ax, ay, bx, by;
    wide_t  axc, ayc, bxc, byc;
    wide_t  dx, dy;
    wide_t  pa, pb, qa, qb;
    logic   reject, steep;
    wide_t  e1;
    logic   last, change;

    logic   req;
    logic   req_vert;
    logic   req_done;
    wide_t  req_col, req_row, req_len;
    color_t req_color;
    wide_t  limit;
    wide_t  len_clip;

    always_comb begin
        w = {{(WIDE_BITS-FIELD_BITS){1'b0}}, width_reg};
        h = {{(WIDE_BITS-FIELD_BITS){1'b0}}, height_reg};

        ax = wide_t'(start_x);
        ay = wide_t'(start_y);
        bx = wide_t'(end_x);
        by = wide_t'(end_y);
        reject = (ay < 0 && by < 0) || (ay > h && by > h) ||
                 (ax < 0 && bx < 0) || (ax > w && bx > w);
        axc = (ax < 0) ? '0 : ax;
        ayc = (ay < 0) ? '0 : ay;
        bxc = (bx < 0) ? '0 : bx;
        byc = (by < 0) ? '0 : by;
        dx = (axc > bxc) ? axc - bxc : bxc - axc;
        dy = (ayc > byc) ? ayc - byc : byc - ayc;
        steep = dy > dx;
        if (steep) begin
            pa = ayc; qa = axc; pb = byc; qb = bxc;
        end else begin
            pa = axc; qa = ayc; pb = bxc; qb = byc;
        end
        if (pa > pb) begin
            pa = steep ? byc : bxc;
            pb = steep ? ayc : axc;
            qa = steep ? bxc : byc;
            qb = steep ? axc : ayc;
        end

        last   = major_pos_reg >= major_end_reg;
        e1     = error_reg - delta_minor_reg;
        change = e1 < 0;

        width_next       = width_reg;
        height_next      = height_reg;
        active_next      = active_reg;
        steep_next       = steep_reg;
        major_pos_next   = major_pos_reg;
        major_end_next   = major_end_reg;
        minor_pos_next   = minor_pos_reg;
        run_start_next   = run_start_reg;
        error_next       = error_reg;
        delta_major_next = delta_major_reg;
        delta_minor_next = delta_minor_reg;
        step_down_next   = step_down_reg;
        color_next       = color_reg;

        req       = 1'b0;
        req_vert  = 1'b0;
        req_done  = 1'b1;
        req_col   = '0;
        req_row   = '0;
        req_len   = '0;
        req_color = color_reg;

        if (cfg_write) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_next  = cfg_data;
                REG_SCREEN_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end

        if (item_accept) begin
            if (command == CMD_LOAD) begin
                active_next = 1'b0;
                color_next  = line_color;
                req_color   = line_color;
                if (!reject) begin
                    if (ayc == byc) begin
                        req     = 1'b1;
                        req_col = (axc < bxc) ? axc : bxc;
                        req_row = ayc;
                        req_len = dx + wide_t'(1);
                    end else if (axc == bxc) begin
                        req      = 1'b1;
                        req_vert = 1'b1;
                        req_col  = axc;
                        req_row  = (ayc < byc) ? ayc : byc;
                        req_len  = dy + wide_t'(1);
                    end else begin
                        active_next      = 1'b1;
                        steep_next       = steep;
                        major_pos_next   = pa;
                        major_end_next   = pb;
                        minor_pos_next   = qa;
                        run_start_next   = pa;
                        delta_major_next = pb - pa;
                        delta_minor_next = (qa > qb) ? qa - qb : qb - qa;
                        error_next       = (pb - pa) >>> 1;
                        step_down_next   = !(qa < qb);
                    end
                end
            end else if (active_reg) begin
                // close the run on a minor change, or flush it at the end of the line
                req      = change || (last && major_pos_reg >= run_start_reg);
                req_vert = steep_reg;
                req_done = last;
                req_len  = major_pos_reg - run_start_reg + wide_t'(1);
                req_col  = steep_reg ? minor_pos_reg : run_start_reg;
                req_row  = steep_reg ? run_start_reg : minor_pos_reg;
                if (change) begin
                    error_next     = e1 + delta_major_reg;
                    run_start_next = major_pos_reg + wide_t'(1);
                    minor_pos_next = step_down_reg ? minor_pos_reg - wide_t'(1)
                                                   : minor_pos_reg + wide_t'(1);
                end else begin
                    error_next = e1;
                end
                major_pos_next = major_pos_reg + wide_t'(1);
                if (last) begin
                    active_next = 1'b0;
                end
            end
        end

        limit    = req_vert ? h - req_row : w - req_col;
        len_clip = (req_len > limit) ? limit : req_len;

        span_valid         = req && req_col < w && req_row < h && req_len >= wide_t'(1);
        span.span_x        = req_col[FIELD_BITS-1:0];
        span.span_y        = req_row[FIELD_BITS-1:0];
        span.span_length   = len_clip[FIELD_BITS-1:0];
        span.span_vertical = req_vert;
        span.span_color    = req_color;
        span.line_done     = req_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            active_reg <= 1'b0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        steep_reg       <= steep_next;
        major_pos_reg   <= major_pos_next;
        major_end_reg   <= major_end_next;
        minor_pos_reg   <= minor_pos_next;
        run_start_reg   <= run_start_next;
        error_reg       <= error_next;
        delta_major_reg <= delta_major_next;
        delta_minor_reg <= delta_minor_next;
        step_down_reg   <= step_down_next;
        color_reg       <= color_next;
    end

endmodule

// File: rtl/lsr_out_stage.sv
// Result register with a skid entry, decoupling the result channel from the input side.
module lsr_out_stage import lsr_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    input  span_t in_span,
    output logic  in_ready,
    output logic  out_valid,
    output span_t out_span,
    input  logic  out_ready
);

    logic  main_valid_reg, main_valid_next;
    logic  skid_valid_reg, skid_valid_next;
    span_t main_reg, main_next;
    span_t skid_reg, skid_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_span  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (out_ready || !main_valid_reg) begin
            if (skid_valid_reg) begin
                // drain the skid entry first
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = in_valid;
                main_next       = in_span;
            end
        end else if (in_valid) begin
            // hold the new item while the receiver stalls
            skid_valid_next = 1'b1;
            skid_next       = in_span;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// File: rtl/line_span_rasterizer_unit.sv
// Line span rasteriser: breaks lines into clipped horizontal or vertical spans.
//
// Input channel (s_*): a load item (command 0) takes two endpoints and a colour;
// a step item (command 1) advances the current line by one major-axis position.
// Result channel (m_*): at most one span per item, marked line_done on the last
// span of a line. Config channel (cfg_*), always ready: index 0 writes the screen
// width, index 1 the height. It must be written by the user only while idle.
//
// The block does not enforce the idle rule. Throughput is one item per cycle
// while s_ready is high: the step and load logic update the line state registers
// in the cycle an item is accepted, and a span passes through the result register
// before m_valid; a setup load, a step inside a run or a clipped span gives none.
//
// When the receiver stalls, one further span is kept in a skid entry and s_ready
// drops until it drains, so no span is lost.
// Reset sets width 320 and height 480, clears any line in progress and empties
// the result register.
module line_span_rasterizer_unit import lsr_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_command,
    input  coord_t                    s_start_x,
    input  coord_t                    s_start_y,
    input  coord_t                    s_end_x,
    input  coord_t                    s_end_y,
    input  color_t                    s_line_color,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  field_t                    cfg_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output field_t                    m_span_x,
    output field_t                    m_span_y,
    output field_t                    m_span_length,
    output logic                      m_span_vertical,
    output color_t                    m_span_color,
    output logic                      m_line_done
);

    logic  span_valid;
    span_t span;
    span_t out_span;
    logic  item_accept;

    assign cfg_ready   = 1'b1;
    assign item_accept = s_valid && s_ready;

    lsr_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (item_accept),
        .command     (s_command),
        .start_x     (s_start_x),
        .start_y     (s_start_y),
        .end_x       (s_end_x),
        .end_y       (s_end_y),
        .line_color  (s_line_color),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .span_valid  (span_valid),
        .span        (span)
    );

    lsr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (span_valid),
        .in_span   (span),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_span  (out_span),
        .out_ready (m_ready)
    );

    assign m_span_x        = out_span.span_x;
    assign m_span_y        = out_span.span_y;
    assign m_span_length   = out_span.span_length;
    assign m_span_vertical = out_span.span_vertical;
    assign m_span_color    = out_span.span_color;
    assign m_line_done     = out_span.line_done;

endmodule

// File: rtl/lsr_checker.sv
// Port-level checks of the line span rasteriser, bound to the top level.
module lsr_checker import lsr_pkg::*; (
    input logic   aclk,
    input logic   aresetn,
    input logic   s_ready,
    input logic   m_valid,
    input logic   m_ready,
    input field_t m_span_x,
    input field_t m_span_y,
    input field_t m_span_length,
    input logic   m_span_vertical,
    input color_t m_span_color,
    input logic   m_line_done
);

    // reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input side only stalls when a span is waiting on the result side
    assert property (@(posedge aclk) disable iff (!aresetn) !s_ready |-> m_valid)
        else $error("input stalled with empty result register");

    // a delivered span is never empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_span_length != '0)
        else $error("zero-length span");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_span_x) && $stable(m_span_y) &&
        $stable(m_span_length) && $stable(m_span_vertical) &&
        $stable(m_span_color) && $stable(m_line_done))
        else $error("stalled span changed");

endmodule

bind line_span_rasterizer_unit lsr_checker u_lsr_checker (.*);
